### hw/rtl/frustum_box_classify_core_defines.svh
// Assertion macros shared by the frustum box classifier RTL.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef FRUSTUM_BOX_CLASSIFY_CORE_DEFINES_SVH
`define FRUSTUM_BOX_CLASSIFY_CORE_DEFINES_SVH

// Condition in one cycle implies a consequence in the same cycle.
`define FBC_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define FBC_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

### hw/rtl/fbc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the frustum box classifier.
// No dependencies; imported by every RTL module of the block.
package fbc_pkg;

    // Default sizes of the block.
    localparam int COORD_BITS_DEF  = 16;
    localparam int PLANE_COUNT_DEF = 6;

    // Plane register file layout.
    localparam int REG_COUNT  = 6;
    localparam int REG_BITS   = 64;
    localparam int ADDR_BITS  = 6;
    localparam int COEF_BITS  = 12;
    localparam int OFFS_BITS  = 28;

    // Field positions inside a packed plane register.
    localparam int COEF_A_LSB = 52;
    localparam int COEF_B_LSB = 40;
    localparam int COEF_C_LSB = 28;

    // Verdict codes.
    localparam logic [1:0] VERDICT_OUT     = 2'd0;
    localparam logic [1:0] VERDICT_CLIP    = 2'd1;
    localparam logic [1:0] VERDICT_CONTAIN = 2'd2;
    localparam logic [1:0] VERDICT_RSVD    = 2'd3;

    // Running classification carried down the cell chain.
    typedef struct packed {
        logic outside;
        logic contain;
    } cull_flags_t;

endpackage

### hw/rtl/fbc_plane_regs.sv
`timescale 1ns / 1ps
// APB-style register file holding the packed frustum planes.
// Depends on fbc_pkg for the register count and address width.
module fbc_plane_regs
    import fbc_pkg::*;
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ADDR_BITS-1:0]               paddr,
    input  logic [REG_BITS-1:0]                pwdata,
    output logic [REG_BITS-1:0]                prdata,
    output logic                               pready,
    output logic [REG_COUNT-1:0][REG_BITS-1:0] planes
);

    logic [REG_COUNT-1:0][REG_BITS-1:0] plane_reg;
    logic [ADDR_BITS-4:0]               reg_idx;
    logic                               idx_valid;
    logic                               wr_en;

    // Registers sit at 8-byte strides.
    assign reg_idx   = paddr[ADDR_BITS-1:3];
    assign idx_valid = (32'(reg_idx) < REG_COUNT);
    assign wr_en     = psel & penable & pwrite & idx_valid;
    assign pready    = 1'b1;

    // Plane storage; writes beyond the register list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg <= '0;
        end
        else if (wr_en)
        begin
            plane_reg[reg_idx] <= pwdata;
        end
    end

    // Read data; unmapped addresses read as zero.
    always_comb
    begin
        if (idx_valid)
        begin
            prdata = plane_reg[reg_idx];
        end
        else
        begin
            prdata = '0;
        end
    end

    assign planes = plane_reg;

endmodule

### hw/rtl/fbc_plane_cell.sv
`timescale 1ns / 1ps
// One cell of the classifier chain: tests the box against a single plane.
// Depends on fbc_pkg for plane field layout and the flag struct.
module fbc_plane_cell
    import fbc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  logic [REG_BITS-1:0]        plane,
    input  logic                       in_valid,
    input  logic [2:0][COORD_BITS-1:0] in_lo,
    input  logic [2:0][COORD_BITS-1:0] in_hi,
    input  cull_flags_t                in_flags,
    output logic                       out_valid,
    output logic [2:0][COORD_BITS-1:0] out_lo,
    output logic [2:0][COORD_BITS-1:0] out_hi,
    output cull_flags_t                out_flags
);

    localparam int PROD_W = COEF_BITS + COORD_BITS;
    localparam int SUM_W  = ((PROD_W > OFFS_BITS) ? PROD_W : OFFS_BITS) + 2;

    logic signed [COEF_BITS-1:0]  coef [3];
    logic signed [OFFS_BITS-1:0]  offs;
    logic signed [COORD_BITS-1:0] lo_s [3];
    logic signed [COORD_BITS-1:0] hi_s [3];
    logic signed [COORD_BITS-1:0] big_c [3];
    logic signed [COORD_BITS-1:0] sml_c [3];
    logic signed [PROD_W-1:0]     pmax_next [3];
    logic signed [PROD_W-1:0]     pmin_next [3];
    logic signed [PROD_W-1:0]     pmax_reg [3];
    logic signed [PROD_W-1:0]     pmin_reg [3];
    logic signed [SUM_W-1:0]      smax;
    logic signed [SUM_W-1:0]      smin;

    logic                         mid_valid_reg;
    logic [2:0][COORD_BITS-1:0]   mid_lo_reg;
    logic [2:0][COORD_BITS-1:0]   mid_hi_reg;
    cull_flags_t                  mid_flags_reg;

    logic                         valid_reg;
    logic [2:0][COORD_BITS-1:0]   lo_reg;
    logic [2:0][COORD_BITS-1:0]   hi_reg;
    cull_flags_t                  flags_reg;
    cull_flags_t                  flags_next;

    // Unpack plane coefficients.
    assign coef[0] = plane[COEF_A_LSB +: COEF_BITS];
    assign coef[1] = plane[COEF_B_LSB +: COEF_BITS];
    assign coef[2] = plane[COEF_C_LSB +: COEF_BITS];
    assign offs    = plane[OFFS_BITS-1:0];

    // Pick the max and min vertex per axis, then form the six products.
    // Sorting each axis first keeps the test exact for inverted boxes.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            lo_s[k]  = in_lo[k];
            hi_s[k]  = in_hi[k];
            big_c[k] = (lo_s[k] > hi_s[k]) ? lo_s[k] : hi_s[k];
            sml_c[k] = (lo_s[k] > hi_s[k]) ? hi_s[k] : lo_s[k];
            if (coef[k][COEF_BITS-1])
            begin
                pmax_next[k] = PROD_W'(coef[k]) * PROD_W'(sml_c[k]);
                pmin_next[k] = PROD_W'(coef[k]) * PROD_W'(big_c[k]);
            end
            else
            begin
                pmax_next[k] = PROD_W'(coef[k]) * PROD_W'(big_c[k]);
                pmin_next[k] = PROD_W'(coef[k]) * PROD_W'(sml_c[k]);
            end
        end
    end

    // First stage: product registers and pass-through of the box.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            mid_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pmax_reg      <= pmax_next;
            pmin_reg      <= pmin_next;
            mid_lo_reg    <= in_lo;
            mid_hi_reg    <= in_hi;
            mid_flags_reg <= in_flags;
        end
    end

    // Second stage: plane sums at the two extreme vertices and flag update.
    always_comb
    begin
        smax = SUM_W'(pmax_reg[0]) + SUM_W'(pmax_reg[1]) + SUM_W'(pmax_reg[2])
             + SUM_W'(offs);
        smin = SUM_W'(pmin_reg[0]) + SUM_W'(pmin_reg[1]) + SUM_W'(pmin_reg[2])
             + SUM_W'(offs);
        flags_next.outside = mid_flags_reg.outside | smax[SUM_W-1];
        flags_next.contain = mid_flags_reg.contain & ~smin[SUM_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= mid_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lo_reg    <= mid_lo_reg;
            hi_reg    <= mid_hi_reg;
            flags_reg <= flags_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_lo    = lo_reg;
    assign out_hi    = hi_reg;
    assign out_flags = flags_reg;

endmodule

### hw/rtl/frustum_box_classify_core.sv
`timescale 1ns / 1ps
// Top level of the frustum box classifier: plane registers, cell chain, result register.
// Depends on fbc_pkg, fbc_plane_regs, fbc_plane_cell and the shared assertion macros.
//
//  channel   | handshake                   | payload
//  ----------+-----------------------------+------------------------------------
//  box       | box_valid / box_ready       | min_x min_y min_z max_x max_y max_z
//  verdict   | verdict_valid/verdict_ready | verdict
//  config    | psel penable pwrite pready  | paddr pwdata prdata
//
// One box request is taken per cycle while the chain is not stalled; its verdict passes
// through two register stages per plane cell, the first one loading at the
// accepting edge, then through the result register.
// Reset clears the plane registers to zero and empties the chain.
// The chain stalls only when a result waits untaken and another one is arriving
// at the end of the chain; the whole chain and box_ready then hold for that cycle.
`include "frustum_box_classify_core_defines.svh"
module frustum_box_classify_core
    import fbc_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int PLANE_COUNT = PLANE_COUNT_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ADDR_BITS-1:0]         paddr,
    input  logic [REG_BITS-1:0]          pwdata,
    output logic [REG_BITS-1:0]          prdata,
    output logic                         pready,
    input  logic                         box_valid,
    output logic                         box_ready,
    input  logic signed [COORD_BITS-1:0] min_x,
    input  logic signed [COORD_BITS-1:0] min_y,
    input  logic signed [COORD_BITS-1:0] min_z,
    input  logic signed [COORD_BITS-1:0] max_x,
    input  logic signed [COORD_BITS-1:0] max_y,
    input  logic signed [COORD_BITS-1:0] max_z,
    output logic                         verdict_valid,
    input  logic                         verdict_ready,
    output logic [1:0]                   verdict
);

    logic [REG_COUNT-1:0][REG_BITS-1:0] planes;
    logic                               adv;
    logic                               last_valid;
    cull_flags_t                        last_flags;
    cull_flags_t                        init_flags;

    logic                               chain_valid [PLANE_COUNT+1];
    logic [2:0][COORD_BITS-1:0]         chain_lo    [PLANE_COUNT+1];
    logic [2:0][COORD_BITS-1:0]         chain_hi    [PLANE_COUNT+1];
    cull_flags_t                        chain_flags [PLANE_COUNT+1];

    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic [1:0]                         verdict_reg;
    logic [1:0]                         verdict_next;

    // Plane register file.
    fbc_plane_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .planes  (planes)
    );

    // Chain input: the request as it arrives, nothing ruled out yet.
    assign init_flags.outside = 1'b0;
    assign init_flags.contain = 1'b1;
    assign chain_valid[0]     = box_valid & box_ready;
    assign chain_lo[0]        = {min_z, min_y, min_x};
    assign chain_hi[0]        = {max_z, max_y, max_x};
    assign chain_flags[0]     = init_flags;

    // One cell per plane; planes past the register file are all zero.
    for (genvar p = 0; p < PLANE_COUNT; p++)
    begin : g_cell
        logic [REG_BITS-1:0] cell_plane;
        if (p < REG_COUNT)
        begin : g_reg
            assign cell_plane = planes[p];
        end
        else
        begin : g_zero
            assign cell_plane = '0;
        end

        fbc_plane_cell #(
            .COORD_BITS (COORD_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .plane     (cell_plane),
            .in_valid  (chain_valid[p]),
            .in_lo     (chain_lo[p]),
            .in_hi     (chain_hi[p]),
            .in_flags  (chain_flags[p]),
            .out_valid (chain_valid[p+1]),
            .out_lo    (chain_lo[p+1]),
            .out_hi    (chain_hi[p+1]),
            .out_flags (chain_flags[p+1])
        );
    end

    assign last_valid = chain_valid[PLANE_COUNT];
    assign last_flags = chain_flags[PLANE_COUNT];

    // The chain moves unless a finished request would hit an occupied result register.
    assign adv       = ~(out_valid_reg & ~verdict_ready & last_valid);
    assign box_ready = adv;

    // Final verdict from the accumulated flags.
    always_comb
    begin
        if (last_flags.outside)
        begin
            verdict_next = VERDICT_OUT;
        end
        else if (last_flags.contain)
        begin
            verdict_next = VERDICT_CONTAIN;
        end
        else
        begin
            verdict_next = VERDICT_CLIP;
        end

        if (adv & last_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (verdict_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv & last_valid)
        begin
            verdict_reg <= verdict_next;
        end
    end

    assign verdict_valid = out_valid_reg;
    assign verdict       = verdict_reg;

    // A new result only appears when the chain delivered one.
    `FBC_ASSERT_NOW(a_result_from_chain, $rose(out_valid_reg), $past(last_valid), "result without chain output")

    // A stalled chain end keeps its request in place.
    `FBC_ASSERT_NEXT(a_stall_holds, out_valid_reg & ~verdict_ready & last_valid, last_valid && $stable(last_flags), "stalled request lost")

    // The reserved verdict code is never delivered.
    `FBC_ASSERT_NOW(a_no_rsvd_code, out_valid_reg, verdict_reg != VERDICT_RSVD, "reserved verdict code")

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for frustum_box_classify_core: box requests in, verdicts out.
// Depends on fbc_pkg and the core RTL; plane registers are loaded over the APB port.
module tb;
    import fbc_pkg::*;

    localparam int PLANES         = PLANE_COUNT_DEF;
    localparam int LATENCY        = 2 * PLANES + 1;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int D_MAX          = (1 << (OFFS_BITS - 1)) - 1;
    localparam int D_MIN          = -(1 << (OFFS_BITS - 1));
    localparam int COEF_MAX       = (1 << (COEF_BITS - 1)) - 1;
    localparam int COEF_MIN       = -(1 << (COEF_BITS - 1));

    typedef enum int {
        PLANE_NEAR, PLANE_FAR, PLANE_LEFT, PLANE_RIGHT, PLANE_TOP, PLANE_BOTTOM,
        PLANE_SPARE0, PLANE_SPARE1
    } plane_idx_t;

    typedef enum int { AXIS_X, AXIS_Y, AXIS_Z } axis_t;

    typedef enum int { RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC, RX_LONG } rx_mode_t;

    typedef logic signed [COORD_BITS_DEF-1:0] coord_t;

    typedef struct packed {
        coord_t [2:0] lo;
        coord_t [2:0] hi;
    } box_t;

    // Holds a copy of the plane registers and the verdicts still owed by the block.
    class verdict_scoreboard;
        logic [REG_BITS-1:0] planes [REG_COUNT];
        logic [1:0]          owed [$];
        int                  errors = 0;

        function void set_plane(int idx, logic [REG_BITS-1:0] value);
            if (idx < REG_COUNT)
                planes[idx] = value;
        endfunction

        // Counts the corners on the inner side of each plane, exactly in 64 bits.
        function logic [1:0] classify(box_t b);
            longint xs [2];
            longint ys [2];
            longint zs [2];
            longint ca, cb, cc, cd, s;
            int     inner;
            int     full;
            bit     culled;
            xs[0] = $signed(b.lo[AXIS_X]);
            xs[1] = $signed(b.hi[AXIS_X]);
            ys[0] = $signed(b.lo[AXIS_Y]);
            ys[1] = $signed(b.hi[AXIS_Y]);
            zs[0] = $signed(b.lo[AXIS_Z]);
            zs[1] = $signed(b.hi[AXIS_Z]);
            culled = 0;
            full = 0;
            for (int p = 0; p < PLANES && !culled; p++)
            begin
                ca = $signed(planes[p][COEF_A_LSB +: COEF_BITS]);
                cb = $signed(planes[p][COEF_B_LSB +: COEF_BITS]);
                cc = $signed(planes[p][COEF_C_LSB +: COEF_BITS]);
                cd = $signed(planes[p][OFFS_BITS-1:0]);
                inner = 0;
                for (int k = 0; k < 8; k++)
                begin
                    s = ca * xs[k & 1] + cb * ys[(k >> 1) & 1] + cc * zs[(k >> 2) & 1] + cd;
                    if (s >= 0)
                        inner++;
                end
                if (inner == 0)
                    culled = 1;
                else if (inner == 8)
                    full++;
            end
            if (culled)
                return VERDICT_OUT;
            if (full == PLANES)
                return VERDICT_CONTAIN;
            return VERDICT_CLIP;
        endfunction

        function void note_box(box_t b);
            owed.push_back(classify(b));
        endfunction

        function void check_verdict(logic [1:0] got);
            logic [1:0] want;
            if (owed.size() == 0)
            begin
                $display("%0t: unexpected verdict, expected none, actual %0d", $time, got);
                errors++;
            end
            else
            begin
                want = owed.pop_front();
                if (got !== want)
                begin
                    $display("%0t: verdict mismatch, expected %0d actual %0d", $time, want, got);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    logic                  clk = 0;
    logic                  rst_n = 0;
    logic                  psel = 0;
    logic                  penable = 0;
    logic                  pwrite = 0;
    logic [ADDR_BITS-1:0]  paddr = '0;
    logic [REG_BITS-1:0]   pwdata = '0;
    logic [REG_BITS-1:0]   prdata;
    logic                  pready;
    logic                  box_valid = 0;
    logic                  box_ready;
    coord_t                min_x = '0;
    coord_t                min_y = '0;
    coord_t                min_z = '0;
    coord_t                max_x = '0;
    coord_t                max_y = '0;
    coord_t                max_z = '0;
    logic                  verdict_valid;
    logic                  verdict_ready = 0;
    logic [1:0]            verdict;

    verdict_scoreboard     sb = new();
    rx_mode_t              rx_mode = RX_ALWAYS;
    int                    rx_tick = 0;
    int                    idle_count = 0;
    axis_t                 plane_axis [REG_COUNT] = '{AXIS_Z, AXIS_Z, AXIS_X, AXIS_X, AXIS_Y, AXIS_Y};

    frustum_box_classify_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .box_valid     (box_valid),
        .box_ready     (box_ready),
        .min_x         (min_x),
        .min_y         (min_y),
        .min_z         (min_z),
        .max_x         (max_x),
        .max_y         (max_y),
        .max_z         (max_z),
        .verdict_valid (verdict_valid),
        .verdict_ready (verdict_ready),
        .verdict       (verdict)
    );

    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    // The verdict side stalls on a pattern that changes now and then.
    always @(negedge clk)
    begin
        rx_tick <= rx_tick + 1;
        case (rx_mode)
            RX_ALWAYS:   verdict_ready <= 1;
            RX_COIN:     verdict_ready <= $urandom_range(0, 1);
            RX_SPARSE:   verdict_ready <= ($urandom_range(0, 3) == 0);
            RX_PERIODIC: verdict_ready <= (rx_tick % 7) < 3;
            default:     verdict_ready <= (rx_tick % 48) >= 40;
        endcase
        if ($urandom_range(0, 199) == 0)
            rx_mode <= rx_mode_t'($urandom_range(0, 4));
    end

    // Sample every handshake at the rising edge and keep the watchdog fed.
    always @(posedge clk)
    begin : monitor
        bit moved;
        moved = 0;
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready)
            begin
                sb.set_plane(paddr / 8, pwdata);
                moved = 1;
            end
            if (box_valid && box_ready)
            begin
                sb.note_box({min_z, min_y, min_x, max_z, max_y, max_x});
                moved = 1;
            end
            if (verdict_valid && verdict_ready)
            begin
                sb.check_verdict(verdict);
                moved = 1;
            end
            idle_count = moved ? 0 : idle_count + 1;
            if (idle_count >= WATCHDOG_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    function automatic logic [REG_BITS-1:0] pack_plane(int a, int b, int c, int d);
        return {12'(a), 12'(b), 12'(c), 28'(d)};
    endfunction

    function automatic coord_t clamp_coord(int v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return -16'sd32768;
        return 16'(v);
    endfunction

    function automatic box_t make_box(int lx, int ly, int lz, int hx, int hy, int hz);
        box_t b;
        b.lo[AXIS_X] = clamp_coord(lx);
        b.lo[AXIS_Y] = clamp_coord(ly);
        b.lo[AXIS_Z] = clamp_coord(lz);
        b.hi[AXIS_X] = clamp_coord(hx);
        b.hi[AXIS_Y] = clamp_coord(hy);
        b.hi[AXIS_Z] = clamp_coord(hz);
        return b;
    endfunction

    function automatic int pick_extreme(int lo_v, int hi_v);
        case ($urandom_range(0, 2))
            0:       return lo_v;
            1:       return hi_v;
            default: return 0;
        endcase
    endfunction

    // Mostly well-formed boxes centred in +/-24000; some raw bit patterns, some inverted.
    function automatic box_t random_box();
        box_t b;
        int   ctr;
        int   half;
        int   t;
        int   sel;
        coord_t swap;
        sel = $urandom_range(0, 9);
        for (int a = 0; a < 3; a++)
        begin
            if (sel == 0)
            begin
                b.lo[a] = 16'($urandom());
                b.hi[a] = 16'($urandom());
            end
            else
            begin
                ctr = int'($urandom_range(0, 48000)) - 24000;
                t = $urandom_range(0, 19);
                half = (t < 14) ? int'($urandom_range(0, 300)) :
                       (t < 19) ? int'($urandom_range(300, 4000)) :
                                  int'($urandom_range(4000, 32767));
                b.lo[a] = clamp_coord(ctr - half);
                b.hi[a] = clamp_coord(ctr + half);
                if (sel == 1 && (a == AXIS_X || $urandom_range(0, 1) == 1))
                begin
                    swap = b.lo[a];
                    b.lo[a] = b.hi[a];
                    b.hi[a] = swap;
                end
            end
        end
        return b;
    endfunction

    task automatic apb_write(int idx, logic [REG_BITS-1:0] value);
        @(negedge clk);
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= ADDR_BITS'(idx * 8);
        pwdata  <= value;
        @(negedge clk);
        penable <= 1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
    endtask

    // Present one box request and hold it until the block takes it.
    task automatic drive_box(box_t b);
        @(negedge clk);
        box_valid <= 1;
        min_x <= b.lo[AXIS_X];
        min_y <= b.lo[AXIS_Y];
        min_z <= b.lo[AXIS_Z];
        max_x <= b.hi[AXIS_X];
        max_y <= b.hi[AXIS_Y];
        max_z <= b.hi[AXIS_Z];
        do @(posedge clk); while (!box_ready);
    endtask

    task automatic idle_for(int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            box_valid <= 0;
        end
    endtask

    // Stop sending and wait for every owed verdict.
    task automatic drain();
        @(negedge clk);
        box_valid <= 0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    // Six slab planes around a random region, pairs facing; allow_zero may clear some.
    task automatic program_slab(bit allow_zero);
        int reach [3];
        int coef [3];
        int mag;
        int sign;
        int d;
        for (int a = 0; a < 3; a++)
            reach[a] = $urandom_range(500, 12000);
        for (int p = PLANE_NEAR; p <= PLANE_BOTTOM; p++)
        begin
            for (int i = 0; i < 3; i++)
                coef[i] = int'($urandom_range(0, 8)) - 4;
            sign = (p % 2 == 0) ? 1 : -1;
            mag = $urandom_range(1, COEF_MAX);
            coef[plane_axis[p]] = sign * mag;
            d = mag * reach[plane_axis[p]] + int'($urandom_range(0, 200)) - 100;
            if (allow_zero && $urandom_range(0, 3) == 0)
                apb_write(p, '0);
            else
                apb_write(p, pack_plane(coef[AXIS_X], coef[AXIS_Y], coef[AXIS_Z], d));
        end
    endtask

    // Raw register patterns, or coefficients and offsets each pinned to a limit or zero.
    task automatic program_wild(bit with_extremes);
        for (int p = PLANE_NEAR; p <= PLANE_BOTTOM; p++)
        begin
            if (with_extremes && $urandom_range(0, 1) == 1)
                apb_write(p, pack_plane(pick_extreme(COEF_MIN, COEF_MAX),
                                        pick_extreme(COEF_MIN, COEF_MAX),
                                        pick_extreme(COEF_MIN, COEF_MAX),
                                        pick_extreme(D_MIN, D_MAX)));
            else
                apb_write(p, {$urandom(), $urandom()});
        end
    endtask

    // Random box stream in bursts, with one full drain somewhere in the middle.
    task automatic run_stream(int count);
        int sent;
        int burst;
        int pause_at;
        sent = 0;
        pause_at = $urandom_range(count / 4, 3 * count / 4);
        while (sent < count)
        begin
            burst = $urandom_range(1, 16);
            for (int i = 0; i < burst && sent < count; i++)
            begin
                drive_box(random_box());
                sent++;
                if (sent == pause_at)
                    drain();
            end
            idle_for(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        // Planes still zero after reset: every box is contained.
        drive_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
        drive_box(make_box(32767, 32767, 32767, -32768, -32768, -32768));
        drive_box(make_box(0, 0, 0, 0, 0, 0));
        drain();

        // Axis-aligned cube of half size 1000, unit normals.
        apb_write(PLANE_NEAR,   pack_plane(0, 0, 1, 1000));
        apb_write(PLANE_FAR,    pack_plane(0, 0, -1, 1000));
        apb_write(PLANE_LEFT,   pack_plane(1, 0, 0, 1000));
        apb_write(PLANE_RIGHT,  pack_plane(-1, 0, 0, 1000));
        apb_write(PLANE_TOP,    pack_plane(0, -1, 0, 1000));
        apb_write(PLANE_BOTTOM, pack_plane(0, 1, 0, 1000));
        // Writes past the last register must leave the planes alone.
        apb_write(PLANE_SPARE0, {64{1'b1}});
        apb_write(PLANE_SPARE1, pack_plane(0, 0, 0, D_MIN));
        drive_box(make_box(-10, -10, -10, 10, 10, 10));
        drive_box(make_box(-2000, -10, -10, 10, 10, 10));
        drive_box(make_box(1500, 0, 0, 1600, 10, 10));
        drive_box(make_box(10, 10, 10, -10, -10, -10));
        drive_box(make_box(2000, 5, 5, -2000, -5, -5));
        drive_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
        // A corner exactly on a plane counts as inside; one step past it does not.
        drive_box(make_box(1000, 1000, 1000, 1000, 1000, 1000));
        drive_box(make_box(1001, 0, 0, 1001, 0, 0));
        drive_box(make_box(-32768, -32768, -32768, -32768, -32768, -32768));
        drain();

        // Coefficients and offsets at their limits, plus an all-ones and an all-zero plane.
        apb_write(PLANE_NEAR,   pack_plane(COEF_MAX, COEF_MAX, COEF_MAX, D_MAX));
        apb_write(PLANE_FAR,    pack_plane(COEF_MIN, COEF_MIN, COEF_MIN, D_MIN));
        apb_write(PLANE_LEFT,   {64{1'b1}});
        apb_write(PLANE_RIGHT,  pack_plane(COEF_MIN, 0, 0, 0));
        apb_write(PLANE_TOP,    '0);
        apb_write(PLANE_BOTTOM, pack_plane(0, 0, COEF_MAX, D_MIN));
        drive_box(make_box(32767, 32767, 32767, 32767, 32767, 32767));
        drive_box(make_box(-32768, -32768, -32768, -32768, -32768, -32768));
        drive_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
        drive_box(make_box(0, 0, 0, 0, 0, 0));
        drive_box(make_box(-1, -1, 32767, -1, -1, 32767));
        drain();

        // Random phases, each with its own plane set.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0:       program_slab(0);
                1:       program_slab(1);
                2:       program_wild(0);
                default: program_wild(1);
            endcase
            run_stream(110);
            drain();
        end

        repeat (2 * LATENCY) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
